[hw/rtl/ivf_pkg.sv]
// Shared types and codes for the inverted-file inner-product search block.
package ivf_pkg;

    localparam int SCORE_W = 39;
    localparam int ID_W    = 10;
    localparam int LIST_W  = 4;
    localparam int EI_W    = 7;
    localparam int TOTAL_W = 11;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_ADDED     = 3'd1,
        ST_NOT_READY = 3'd2,
        ST_LIST_FULL = 3'd3,
        ST_NO_MATCH  = 3'd4,
        ST_REFUSED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ELEM  = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_kind_t;

    localparam logic [1:0] CFG_DIM   = 2'd0;
    localparam logic [1:0] CFG_LISTS = 2'd1;
    localparam logic [1:0] CFG_TOPK  = 2'd2;
    localparam logic [1:0] CFG_PROBE = 2'd3;

    // Classified element command passed from front to back
    typedef struct packed {
        cmd_kind_t         kind;
        logic              load_ok;
        logic              load_last;
        logic [LIST_W-1:0] li;
        logic [EI_W-1:0]   ei;
    } cmd_ctl_t;

    // Clamped configuration values
    typedef struct packed {
        logic [7:0] dim;
        logic [4:0] lists;
        logic [4:0] top_k;
        logic [4:0] probes;
    } cfg_t;

endpackage

[hw/rtl/ivf_front.sv]
// Input classifier: drops ignored items and tags the rest for the back end.
module ivf_front import ivf_pkg::*; #(
    parameter int NLIST_MAX = 16,
    parameter int ELEM_BITS = 16
) (
    input  cfg_t                 cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [LIST_W-1:0]    s_list_index,
    input  logic [EI_W-1:0]      s_element_index,
    input  logic [ELEM_BITS-1:0] s_element_value,
    input  logic                 fifo_full,
    output logic                 push,
    output cmd_ctl_t             push_ctl,
    output logic [ELEM_BITS-1:0] push_val
);

    logic keep;
    logic in_dim;
    logic is_last;
    logic li_ok;

    assign in_dim  = {1'b0, s_element_index} < cfg.dim;
    assign is_last = {1'b0, s_element_index} == (cfg.dim - 8'd1);
    assign li_ok   = 32'(s_list_index) < NLIST_MAX;

    // Classify the element
    always_comb begin
        keep        = 1'b0;
        push_ctl    = '0;
        push_ctl.li = s_list_index;
        push_ctl.ei = s_element_index;
        unique case (s_req_type)
            REQ_LOAD: begin
                keep               = 1'b1;
                push_ctl.kind      = CMD_LOAD;
                push_ctl.load_ok   = in_dim && li_ok;
                push_ctl.load_last = is_last && ({1'b0, s_list_index} == (cfg.lists - 5'd1));
            end
            REQ_ADD: begin
                keep          = in_dim;
                push_ctl.kind = is_last ? CMD_ADD : CMD_ELEM;
            end
            REQ_QUERY: begin
                keep          = in_dim;
                push_ctl.kind = is_last ? CMD_QUERY : CMD_ELEM;
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_ready  = !fifo_full;
    assign push     = s_valid && !fifo_full && keep;
    assign push_val = s_element_value;

endmodule

[hw/rtl/ivf_cmd_fifo.sv]
// Two-entry command queue between the front and the back end.
module ivf_cmd_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = cnt_reg == 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop) cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hw/rtl/ivf_back.sv]
// Back end: stores, dot-product unit, list assignment, probe scan and top-k.
module ivf_back import ivf_pkg::*; #(
    parameter int DIM_MAX   = 128,
    parameter int NLIST_MAX = 16,
    parameter int LIST_CAP  = 64,
    parameter int K_MAX     = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 cmd_valid,
    input  cmd_ctl_t             cmd_ctl,
    input  logic [ELEM_BITS-1:0] cmd_val,
    output logic                 cmd_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [ID_W-1:0]      m_result_id,
    output logic [LIST_W-1:0]    m_result_list,
    output logic [SCORE_W-1:0]   m_result_score,
    output logic                 m_last_result
);

    localparam int LI_W       = NLIST_MAX > 1 ? $clog2(NLIST_MAX) : 1;
    localparam int LC_W       = $clog2(NLIST_MAX + 1);
    localparam int DI_W       = DIM_MAX > 1 ? $clog2(DIM_MAX) : 1;
    localparam int DC_W       = $clog2(DIM_MAX + 1);
    localparam int FC_W       = $clog2(LIST_CAP + 1);
    localparam int KC_W       = $clog2(K_MAX + 1);
    localparam int KI_W       = K_MAX > 1 ? $clog2(K_MAX) : 1;
    localparam int CENT_DEPTH = NLIST_MAX * DIM_MAX;
    localparam int CA_W       = CENT_DEPTH > 1 ? $clog2(CENT_DEPTH) : 1;
    localparam int SLOTS      = NLIST_MAX * LIST_CAP;
    localparam int SA_W       = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int VEC_DEPTH  = SLOTS * DIM_MAX;
    localparam int VA_W       = VEC_DEPTH > 1 ? $clog2(VEC_DEPTH) : 1;
    localparam int PROD_W     = 2 * ELEM_BITS;
    localparam int ACC_W      = 2 * ELEM_BITS + DC_W;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DOT     = 8'b0000_0010,
        S_POST    = 8'b0000_0100,
        S_ADD_CHK = 8'b0000_1000,
        S_COPY    = 8'b0001_0000,
        S_PROBE   = 8'b0010_0000,
        S_EMIT    = 8'b0100_0000,
        S_ONE     = 8'b1000_0000
    } state_t;

    // Memories
    logic signed [ELEM_BITS-1:0] pend_mem [DIM_MAX];
    logic signed [ELEM_BITS-1:0] cent_mem [CENT_DEPTH];
    logic signed [ELEM_BITS-1:0] vec_mem  [VEC_DEPTH];
    logic        [ID_W-1:0]      id_mem   [SLOTS];

    logic signed [ELEM_BITS-1:0] pend_q;
    logic signed [ELEM_BITS-1:0] cent_q;
    logic signed [ELEM_BITS-1:0] vec_q;
    logic        [ID_W-1:0]      id_q;

    // Control and datapath registers
    state_t                   state_reg;
    logic                     ready_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic [FC_W-1:0]          fill_reg [NLIST_MAX];
    logic                     is_query_reg;
    logic                     src_vec_reg;
    logic [LC_W-1:0]          c_reg;
    logic [CA_W-1:0]          cbase_reg;
    logic [VA_W-1:0]          vbase_reg;
    logic [DC_W-1:0]          iss_reg;
    logic                     rd_v_reg;
    logic                     mul_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [LI_W-1:0]          best_reg;
    logic signed [ACC_W-1:0]  bs_reg;
    logic                     cp_v_reg;
    logic [DI_W-1:0]          cp_idx_reg;
    logic signed [ACC_W-1:0]  rank_sc_reg [NLIST_MAX];
    logic [LI_W-1:0]          rank_id_reg [NLIST_MAX];
    logic [LC_W-1:0]          p_reg;
    logic [FC_W-1:0]          s_reg;
    logic [LI_W-1:0]          ls_reg;
    logic signed [ACC_W-1:0]  tk_sc_reg [K_MAX];
    logic [ID_W-1:0]          tk_id_reg [K_MAX];
    logic [LI_W-1:0]          tk_ls_reg [K_MAX];
    logic [KC_W-1:0]          tk_cnt_reg;
    logic [KC_W-1:0]          emit_idx_reg;
    status_t                  one_status_reg;
    logic [ID_W-1:0]          one_id_reg;
    logic [LIST_W-1:0]        one_list_reg;
    logic                     m_valid_reg;
    logic [2:0]               m_status_reg;
    logic [ID_W-1:0]          m_id_reg;
    logic [LIST_W-1:0]        m_list_reg;
    logic [SCORE_W-1:0]       m_score_reg;
    logic                     m_last_reg;

    // Combinational helpers
    logic                     out_free;
    logic                     out_load;
    logic                     issue;
    logic                     cp_issue;
    logic                     dot_done;
    logic                     pend_we;
    logic                     cent_we;
    logic [CA_W-1:0]          cent_waddr;
    logic signed [ELEM_BITS-1:0] mul_b;
    logic [LI_W-1:0]          probe_ls;
    logic [SA_W-1:0]          probe_slot;
    logic [SA_W-1:0]          add_slot;
    logic                     id_we;
    logic                     id_re;
    logic [NLIST_MAX:0]       rgx;
    logic signed [ACC_W-1:0]  rank_sc_n [NLIST_MAX];
    logic [LI_W-1:0]          rank_id_n [NLIST_MAX];
    logic [K_MAX:0]           kbx;
    logic signed [ACC_W-1:0]  tk_sc_n [K_MAX];
    logic [ID_W-1:0]          tk_id_n [K_MAX];
    logic [LI_W-1:0]          tk_ls_n [K_MAX];
    logic                     tk_accept;

    function automatic logic beats(input logic signed [ACC_W-1:0] sa, input logic [ID_W-1:0] ia,
                                   input logic signed [ACC_W-1:0] sb, input logic [ID_W-1:0] ib);
        return (sa > sb) || ((sa == sb) && (ia < ib));
    endfunction

    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = ((state_reg == S_EMIT) || (state_reg == S_ONE)) && out_free;
    assign cmd_pop    = (state_reg == S_IDLE) && cmd_valid;
    assign issue      = (state_reg == S_DOT) && (32'(iss_reg) < 32'(cfg.dim));
    assign cp_issue   = (state_reg == S_COPY) && (32'(iss_reg) < DIM_MAX);
    assign dot_done   = (state_reg == S_DOT) && !issue && !rd_v_reg && !mul_v_reg;
    assign pend_we    = cmd_pop && (cmd_ctl.kind != CMD_LOAD);
    assign cent_we    = cmd_pop && (cmd_ctl.kind == CMD_LOAD) && (total_reg == '0)
                        && cmd_ctl.load_ok;
    assign cent_waddr = CA_W'(32'(cmd_ctl.li) * DIM_MAX + 32'(cmd_ctl.ei));
    assign mul_b      = src_vec_reg ? vec_q : cent_q;
    assign probe_ls   = rank_id_reg[LI_W'(p_reg)];
    assign probe_slot = SA_W'(32'(probe_ls) * LIST_CAP + 32'(s_reg));
    assign add_slot   = SA_W'(32'(best_reg) * LIST_CAP + 32'(fill_reg[best_reg]));
    assign id_we      = (state_reg == S_ADD_CHK) && (32'(fill_reg[best_reg]) < LIST_CAP);
    assign id_re      = (state_reg == S_PROBE);

    // Pending vector memory
    always_ff @(posedge aclk) begin
        if (pend_we) pend_mem[DI_W'(cmd_ctl.ei)] <= cmd_val;
        pend_q <= pend_mem[DI_W'(iss_reg)];
    end

    // Centroid memory
    always_ff @(posedge aclk) begin
        if (cent_we) cent_mem[cent_waddr] <= cmd_val;
        cent_q <= cent_mem[cbase_reg + CA_W'(iss_reg)];
    end

    // Vector memory
    always_ff @(posedge aclk) begin
        if (cp_v_reg) vec_mem[vbase_reg + VA_W'(cp_idx_reg)] <= pend_q;
        vec_q <= vec_mem[vbase_reg + VA_W'(iss_reg)];
    end

    // Id memory
    always_ff @(posedge aclk) begin
        if (id_we) id_mem[add_slot] <= total_reg[ID_W-1:0];
        if (id_re) id_q <= id_mem[probe_slot];
    end

    // Insert the finished centroid score into the ranking
    always_comb begin
        rgx[0] = 1'b1;
        for (int j = 0; j < NLIST_MAX; j++) begin
            rgx[j+1]     = (32'(j) < 32'(c_reg)) && (rank_sc_reg[j] >= acc_reg);
            rank_sc_n[j] = rank_sc_reg[j];
            rank_id_n[j] = rank_id_reg[j];
        end
        for (int j = 1; j < NLIST_MAX; j++) begin
            if (!rgx[j]) begin
                rank_sc_n[j] = rank_sc_reg[j-1];
                rank_id_n[j] = rank_id_reg[j-1];
            end
        end
        for (int j = 0; j < NLIST_MAX; j++) begin
            if (rgx[j] && !rgx[j+1]) begin
                rank_sc_n[j] = acc_reg;
                rank_id_n[j] = LI_W'(c_reg);
            end
        end
    end

    // Insert the finished hit into the top-k buffer
    always_comb begin
        kbx[0] = 1'b1;
        for (int j = 0; j < K_MAX; j++) begin
            kbx[j+1]   = (32'(j) < 32'(tk_cnt_reg))
                         && !beats(acc_reg, id_q, tk_sc_reg[j], tk_id_reg[j]);
            tk_sc_n[j] = tk_sc_reg[j];
            tk_id_n[j] = tk_id_reg[j];
            tk_ls_n[j] = tk_ls_reg[j];
        end
        for (int j = 1; j < K_MAX; j++) begin
            if (!kbx[j]) begin
                tk_sc_n[j] = tk_sc_reg[j-1];
                tk_id_n[j] = tk_id_reg[j-1];
                tk_ls_n[j] = tk_ls_reg[j-1];
            end
        end
        for (int j = 0; j < K_MAX; j++) begin
            if (kbx[j] && !kbx[j+1]) begin
                tk_sc_n[j] = acc_reg;
                tk_id_n[j] = id_q;
                tk_ls_n[j] = ls_reg;
            end
        end
        tk_accept = !kbx[KC_W'(cfg.top_k)];
    end

    // Multiply-accumulate pipeline
    always_ff @(posedge aclk) begin
        prod_reg <= pend_q * mul_b;
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ready_reg   <= 1'b0;
            total_reg   <= '0;
            rd_v_reg    <= 1'b0;
            mul_v_reg   <= 1'b0;
            cp_v_reg    <= 1'b0;
            tk_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < NLIST_MAX; j++) fill_reg[j] <= '0;
        end else begin
            rd_v_reg  <= issue;
            mul_v_reg <= rd_v_reg;
            cp_v_reg  <= cp_issue;
            if (mul_v_reg) acc_reg <= acc_reg + ACC_W'(prod_reg);
            if (m_valid_reg && m_ready && !out_load) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        case (cmd_ctl.kind)
                            CMD_LOAD: begin
                                if (total_reg != '0) begin
                                    one_status_reg <= ST_REFUSED;
                                    one_id_reg     <= '0;
                                    one_list_reg   <= '0;
                                    state_reg      <= S_ONE;
                                end else if (cmd_ctl.load_ok && cmd_ctl.load_last) begin
                                    ready_reg <= 1'b1;
                                end
                            end
                            CMD_ADD, CMD_QUERY: begin
                                if (!ready_reg) begin
                                    one_status_reg <= ST_NOT_READY;
                                    one_id_reg     <= '0;
                                    one_list_reg   <= '0;
                                    state_reg      <= S_ONE;
                                end else begin
                                    is_query_reg <= (cmd_ctl.kind == CMD_QUERY);
                                    c_reg        <= '0;
                                    cbase_reg    <= '0;
                                    src_vec_reg  <= 1'b0;
                                    iss_reg      <= '0;
                                    acc_reg      <= '0;
                                    state_reg    <= S_DOT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DOT: begin
                    if (issue) iss_reg <= iss_reg + DC_W'(1);
                    if (dot_done) state_reg <= S_POST;
                end
                S_POST: begin
                    if (src_vec_reg) begin
                        // Fold the scanned vector into the top-k buffer
                        if (tk_accept) begin
                            for (int j = 0; j < K_MAX; j++) begin
                                tk_sc_reg[j] <= tk_sc_n[j];
                                tk_id_reg[j] <= tk_id_n[j];
                                tk_ls_reg[j] <= tk_ls_n[j];
                            end
                            if (32'(tk_cnt_reg) < 32'(cfg.top_k))
                                tk_cnt_reg <= tk_cnt_reg + KC_W'(1);
                        end
                        s_reg     <= s_reg + FC_W'(1);
                        state_reg <= S_PROBE;
                    end else begin
                        if (!is_query_reg) begin
                            if (c_reg == '0 || acc_reg > bs_reg) begin
                                bs_reg   <= acc_reg;
                                best_reg <= LI_W'(c_reg);
                            end
                        end else begin
                            for (int j = 0; j < NLIST_MAX; j++) begin
                                rank_sc_reg[j] <= rank_sc_n[j];
                                rank_id_reg[j] <= rank_id_n[j];
                            end
                        end
                        if (32'(c_reg) + 1 < 32'(cfg.lists)) begin
                            c_reg     <= c_reg + LC_W'(1);
                            cbase_reg <= cbase_reg + CA_W'(DIM_MAX);
                            iss_reg   <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_DOT;
                        end else if (!is_query_reg) begin
                            state_reg <= S_ADD_CHK;
                        end else begin
                            p_reg      <= '0;
                            s_reg      <= '0;
                            tk_cnt_reg <= '0;
                            state_reg  <= S_PROBE;
                        end
                    end
                end
                S_ADD_CHK: begin
                    if (32'(fill_reg[best_reg]) >= LIST_CAP) begin
                        one_status_reg <= ST_LIST_FULL;
                        one_id_reg     <= '0;
                        one_list_reg   <= LIST_W'(best_reg);
                        state_reg      <= S_ONE;
                    end else begin
                        vbase_reg <= VA_W'(32'(add_slot) * DIM_MAX);
                        iss_reg   <= '0;
                        state_reg <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (cp_issue) begin
                        iss_reg    <= iss_reg + DC_W'(1);
                        cp_idx_reg <= DI_W'(iss_reg);
                    end
                    if (!cp_issue && !cp_v_reg) begin
                        fill_reg[best_reg] <= fill_reg[best_reg] + FC_W'(1);
                        one_status_reg     <= ST_ADDED;
                        one_id_reg         <= total_reg[ID_W-1:0];
                        one_list_reg       <= LIST_W'(best_reg);
                        total_reg          <= total_reg + TOTAL_W'(1);
                        state_reg          <= S_ONE;
                    end
                end
                S_PROBE: begin
                    if (s_reg < fill_reg[probe_ls]) begin
                        ls_reg      <= probe_ls;
                        vbase_reg   <= VA_W'(32'(probe_slot) * DIM_MAX);
                        src_vec_reg <= 1'b1;
                        iss_reg     <= '0;
                        acc_reg     <= '0;
                        state_reg   <= S_DOT;
                    end else if (32'(p_reg) + 1 >= 32'(cfg.probes)) begin
                        emit_idx_reg <= '0;
                        state_reg    <= S_EMIT;
                    end else begin
                        p_reg <= p_reg + LC_W'(1);
                        s_reg <= '0;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (tk_cnt_reg == '0) begin
                            m_status_reg <= ST_NO_MATCH;
                            m_id_reg     <= '0;
                            m_list_reg   <= '0;
                            m_score_reg  <= '0;
                            m_last_reg   <= 1'b1;
                            state_reg    <= S_IDLE;
                        end else begin
                            m_status_reg <= ST_HIT;
                            m_id_reg     <= tk_id_reg[emit_idx_reg[KI_W-1:0]];
                            m_list_reg   <= LIST_W'(tk_ls_reg[emit_idx_reg[KI_W-1:0]]);
                            m_score_reg  <= SCORE_W'(tk_sc_reg[emit_idx_reg[KI_W-1:0]]);
                            m_last_reg   <= (emit_idx_reg + KC_W'(1)) == tk_cnt_reg;
                            emit_idx_reg <= emit_idx_reg + KC_W'(1);
                            if ((emit_idx_reg + KC_W'(1)) == tk_cnt_reg) state_reg <= S_IDLE;
                        end
                    end
                end
                S_ONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= one_status_reg;
                        m_id_reg     <= one_id_reg;
                        m_list_reg   <= one_list_reg;
                        m_score_reg  <= '0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_id    = m_id_reg;
    assign m_result_list  = m_list_reg;
    assign m_result_score = m_score_reg;
    assign m_last_result  = m_last_reg;

endmodule

[hw/rtl/ivf_topk_inner_product_search.sv]
// Top level of the inverted-file top-k inner-product search block.
// Elements arrive one per transfer and pass a two-entry queue; loads and
// non-final elements are stored as the back end takes them, and the queue
// fills and holds off input while the back end works on a final element. A
// final add element scores every list in use against its centroid, then
// copies the vector into the best list; a final query element scores every
// centroid, then scans the stored vectors of the probed lists. This work runs
// on the single multiply-accumulate unit and the one read port of each store.
module ivf_topk_inner_product_search import ivf_pkg::*; #(
    parameter int DIM_MAX   = 128,
    parameter int NLIST_MAX = 16,
    parameter int LIST_CAP  = 64,
    parameter int K_MAX     = 16,
    parameter int ELEM_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [LIST_W-1:0]    s_list_index,
    input  logic [EI_W-1:0]      s_element_index,
    input  logic [ELEM_BITS-1:0] s_element_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [ID_W-1:0]      m_result_id,
    output logic [LIST_W-1:0]    m_result_list,
    output logic [SCORE_W-1:0]   m_result_score,
    output logic                 m_last_result
);

    localparam int QW = $bits(cmd_ctl_t) + ELEM_BITS;

    logic [7:0]           dim_reg;
    logic [4:0]           lists_reg;
    logic [4:0]           topk_reg;
    logic [4:0]           probe_reg;
    cfg_t                 cfg;
    logic                 fifo_full;
    logic                 push;
    cmd_ctl_t             push_ctl;
    logic [ELEM_BITS-1:0] push_val;
    logic                 head_valid;
    logic [QW-1:0]        head_data;
    logic                 pop;
    cmd_ctl_t             head_ctl;
    logic [ELEM_BITS-1:0] head_val;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg   <= 8'd128;
            lists_reg <= 5'd16;
            topk_reg  <= 5'd1;
            probe_reg <= 5'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DIM:   dim_reg   <= cfg_wdata;
                CFG_LISTS: lists_reg <= cfg_wdata[4:0];
                CFG_TOPK:  topk_reg  <= cfg_wdata[4:0];
                CFG_PROBE: probe_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Clamp configuration to usable ranges
    always_comb begin
        cfg.dim    = (dim_reg == '0) ? 8'd1 :
                     (32'(dim_reg) > DIM_MAX) ? 8'(DIM_MAX) : dim_reg;
        cfg.lists  = (lists_reg == '0) ? 5'd1 :
                     (32'(lists_reg) > NLIST_MAX) ? 5'(NLIST_MAX) : lists_reg;
        cfg.top_k  = (topk_reg == '0) ? 5'd1 :
                     (32'(topk_reg) > K_MAX) ? 5'(K_MAX) : topk_reg;
        cfg.probes = (probe_reg == '0) ? 5'd1 :
                     (probe_reg > cfg.lists) ? cfg.lists : probe_reg;
    end

    ivf_front #(
        .NLIST_MAX (NLIST_MAX),
        .ELEM_BITS (ELEM_BITS)
    ) u_front (
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_list_index    (s_list_index),
        .s_element_index (s_element_index),
        .s_element_value (s_element_value),
        .fifo_full       (fifo_full),
        .push            (push),
        .push_ctl        (push_ctl),
        .push_val        (push_val)
    );

    ivf_cmd_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  ({push_ctl, push_val}),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_ctl = head_data[QW-1:ELEM_BITS];
    assign head_val = head_data[ELEM_BITS-1:0];

    ivf_back #(
        .DIM_MAX   (DIM_MAX),
        .NLIST_MAX (NLIST_MAX),
        .LIST_CAP  (LIST_CAP),
        .K_MAX     (K_MAX),
        .ELEM_BITS (ELEM_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd_valid      (head_valid),
        .cmd_ctl        (head_ctl),
        .cmd_val        (head_val),
        .cmd_pop        (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_id    (m_result_id),
        .m_result_list  (m_result_list),
        .m_result_score (m_result_score),
        .m_last_result  (m_last_result)
    );

`ifndef SYNTHESIS
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_HIT) |-> m_last_result)
        else $error("non-hit result without last flag");

    a_zero_score: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_HIT) |-> (m_result_score == '0))
        else $error("non-hit result with nonzero score");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("back end took a command from an empty queue");
`endif

endmodule
